>>> rtl/sic_pkg.sv
// Shared types, codes and sizes for the subset instruction core.
// No dependencies; the RTL files refer to it by scoped names and the testbench imports it.
`default_nettype none

package sic_pkg;

    // Data memory size in words; must stay a power of two (index is a bit slice).
    localparam int unsigned MEM_WORDS = 1024;
    localparam int unsigned MEM_AW    = $clog2(MEM_WORDS);

    // Result queue depth; also bounds the words in flight through the core.
    localparam int unsigned OUT_DEPTH = 4;
    localparam int unsigned OUT_AW    = $clog2(OUT_DEPTH);
    localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    localparam int unsigned IN_TDATA_W  = 32;
    localparam int unsigned RES_W       = 32 + 1 + 4 + 32 + 1 + 1 + 1 + 1;
    localparam int unsigned OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

    localparam logic [31:0] HALT_WORD = 32'hEF00_0011;

    typedef enum logic [1:0] {
        FMT_DP   = 2'd0,
        FMT_XFER = 2'd1,
        FMT_BR   = 2'd2,
        FMT_RSVD = 2'd3
    } fmt_t;

    // Data processing opcodes
    localparam logic [3:0] OP_AND = 4'd0;
    localparam logic [3:0] OP_EOR = 4'd1;
    localparam logic [3:0] OP_SUB = 4'd2;
    localparam logic [3:0] OP_ADD = 4'd4;
    localparam logic [3:0] OP_ADC = 4'd5;
    localparam logic [3:0] OP_CMP = 4'd10;
    localparam logic [3:0] OP_ORR = 4'd12;
    localparam logic [3:0] OP_MOV = 4'd13;
    localparam logic [3:0] OP_MVN = 4'd15;

    // Transfer codes, bits 25..20
    localparam logic [5:0] XOP_STR = 6'd24;
    localparam logic [5:0] XOP_LDR = 6'd25;

    // Branch conditions
    localparam logic [3:0] COND_EQ = 4'd0;
    localparam logic [3:0] COND_NE = 4'd1;
    localparam logic [3:0] COND_GE = 4'd10;
    localparam logic [3:0] COND_LT = 4'd11;
    localparam logic [3:0] COND_GT = 4'd12;
    localparam logic [3:0] COND_LE = 4'd13;
    localparam logic [3:0] COND_AL = 4'd14;

    typedef struct packed {
        logic n;
        logic z;
        logic c;
    } flags_t;

    typedef struct packed {
        logic [31:0] next_fetch;
        logic        reg_write_en;
        logic [3:0]  reg_index;
        logic [31:0] reg_value;
        logic        flag_n;
        logic        flag_z;
        logic        flag_c;
        logic        halted;
    } result_t;

    typedef struct packed {
        logic        en;
        logic [3:0]  idx;
        logic [31:0] data;
    } rf_wr_t;

    typedef struct packed {
        logic              wr;
        logic [MEM_AW-1:0] addr;
        logic [31:0]       data;
    } mem_req_t;

endpackage

`default_nettype wire

>>> rtl/arm_subset_instruction_core.sv
// Top level of the subset instruction core: operand read, execute, writeback
// and result queue. Depends on sic_pkg, sic_regfile, sic_dmem, sic_execute, sic_out_fifo.
//
//  channel | direction | word                | fields, low bit first
//  --------+-----------+---------------------+------------------------------------
//  s_*     | in        | one instruction     | instr_word[31:0]
//  m_*     | out       | one retired result  | next_fetch, reg_write_en, reg_index,
//          |           |                     | reg_value, flag_n, flag_z, flag_c,
//          |           |                     | halted, 7 zero pad bits
//
// One instruction word is taken per clock while s_tready is high. The register file
// is read and the word is held in p1_instr_reg when it is taken; execute (ALU, flags,
// branch, memory access) works from them into p2_res_reg and the data memory read
// register, and writeback pushes the result into the result queue that drives m_tvalid.
// Results from back-to-back words stream out one per clock while m_tready is high; data
// hazards are covered by forwarding, so there are no bubbles.
// After reset the data memory is swept to zero, one word a cycle, through all MEM_WORDS
// (1024) words; s_tready stays low until the sweep ends.
// The core accepts words while fewer than OUT_DEPTH words are taken but not yet
// delivered, so a stalled m_tready backs up into s_tready only after that.
`default_nettype none

module arm_subset_instruction_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [sic_pkg::IN_TDATA_W-1:0]    s_tdata,   // instr_word[31:0]
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // next_fetch[31:0], reg_write_en[32], reg_index[36:33], reg_value[68:37],
    // flag_n[69], flag_z[70], flag_c[71], halted[72], zero[79:73]
    output logic [sic_pkg::OUT_TDATA_W-1:0]        m_tdata
);

    logic                           in_acc;
    logic                           out_acc;

    // Stage 1: word under execution
    logic                           p1_valid_reg;
    logic [31:0]                    p1_instr_reg;

    // Stage 2: writeback
    logic                           p2_valid_reg;
    sic_pkg::result_t               p2_res_reg;
    logic                           p2_load_reg;

    // Architectural state kept in flops
    logic [31:0]                    pc_reg;
    sic_pkg::flags_t                flags_reg;

    // Last register write, for forwarding past the register-file read
    sic_pkg::rf_wr_t                wb_reg;

    logic [3:0]                     rf_raddr_b;
    logic [31:0]                    rf_rdata_a;
    logic [31:0]                    rf_rdata_b;
    logic [3:0]                     p1_idx_b;
    logic [31:0]                    op_a;
    logic [31:0]                    op_b;

    sic_pkg::result_t               exe_res;
    logic                           exe_load;
    sic_pkg::mem_req_t              exe_mem_req;
    sic_pkg::flags_t                exe_flags;

    logic [31:0]                    mem_rdata;
    logic                           mem_busy;

    logic [31:0]                    p2_value;
    sic_pkg::rf_wr_t                rf_wr;
    sic_pkg::result_t               wb_res;

    sic_pkg::result_t               q_head;
    logic                           q_not_empty;
    logic [sic_pkg::OUT_CNT_W-1:0]  q_count;
    logic [sic_pkg::OUT_CNT_W-1:0]  in_flight;

    // Pick the newest value of a register: writeback stage, last write, array
    function automatic logic [31:0] fwd_sel(
        input logic [3:0]      idx,
        input logic [31:0]     raw,
        input logic            p2_hit,
        input logic [3:0]      p2_idx,
        input logic [31:0]     p2_val,
        input sic_pkg::rf_wr_t last_wr
    );
        logic [31:0] val;
        begin
            val = raw;
            if (p2_hit && (p2_idx == idx))
            begin
                val = p2_val;
            end
            else if (last_wr.en && (last_wr.idx == idx))
            begin
                val = last_wr.data;
            end
            return val;
        end
    endfunction

    // Hold new words back during the memory sweep or with the queue budget used up
    assign in_flight = q_count + sic_pkg::OUT_CNT_W'(p1_valid_reg)
                     + sic_pkg::OUT_CNT_W'(p2_valid_reg);
    assign s_tready  = !mem_busy && (in_flight < sic_pkg::OUT_CNT_W'(sic_pkg::OUT_DEPTH));
    assign in_acc    = s_tvalid && s_tready;
    assign out_acc   = m_tvalid && m_tready;

    // Port B serves Rd for transfers (store data) and Rm otherwise
    assign rf_raddr_b = (sic_pkg::fmt_t'(s_tdata[27:26]) == sic_pkg::FMT_XFER)
                      ? s_tdata[15:12] : s_tdata[3:0];

    sic_regfile u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .raddr_a (s_tdata[19:16]),
        .raddr_b (rf_raddr_b),
        .rdata_a (rf_rdata_a),
        .rdata_b (rf_rdata_b),
        .wr      (rf_wr)
    );

    assign p1_idx_b = (sic_pkg::fmt_t'(p1_instr_reg[27:26]) == sic_pkg::FMT_XFER)
                    ? p1_instr_reg[15:12] : p1_instr_reg[3:0];

    // Load data arrives from memory during writeback
    assign p2_value = p2_load_reg ? mem_rdata : p2_res_reg.reg_value;

    assign op_a = fwd_sel(p1_instr_reg[19:16], rf_rdata_a,
                          p2_valid_reg && p2_res_reg.reg_write_en,
                          p2_res_reg.reg_index, p2_value, wb_reg);
    assign op_b = fwd_sel(p1_idx_b, rf_rdata_b,
                          p2_valid_reg && p2_res_reg.reg_write_en,
                          p2_res_reg.reg_index, p2_value, wb_reg);

    sic_execute u_execute (
        .valid      (p1_valid_reg),
        .instr      (p1_instr_reg),
        .op_a       (op_a),
        .op_b       (op_b),
        .pc         (pc_reg),
        .flags      (flags_reg),
        .res        (exe_res),
        .is_load    (exe_load),
        .mem_req    (exe_mem_req),
        .flags_next (exe_flags)
    );

    sic_dmem u_dmem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (exe_mem_req),
        .rdata (mem_rdata),
        .busy  (mem_busy)
    );

    // Writeback: one register write port, shared by ALU results and loads
    always_comb
    begin
        rf_wr.en   = p2_valid_reg && p2_res_reg.reg_write_en;
        rf_wr.idx  = p2_res_reg.reg_index;
        rf_wr.data = p2_value;

        wb_res           = p2_res_reg;
        wb_res.reg_value = p2_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            pc_reg       <= '0;
            flags_reg    <= '0;
            wb_reg       <= '0;
        end
        else
        begin
            p1_valid_reg <= in_acc;
            p2_valid_reg <= p1_valid_reg;
            wb_reg       <= rf_wr;
            // Advance PC and flags as each word leaves execute
            if (p1_valid_reg)
            begin
                pc_reg    <= exe_res.next_fetch;
                flags_reg <= exe_flags;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            p1_instr_reg <= s_tdata[31:0];
        end
        p2_res_reg  <= exe_res;
        p2_load_reg <= exe_load;
    end

    sic_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (p2_valid_reg),
        .push_data (wb_res),
        .pop       (out_acc),
        .head      (q_head),
        .not_empty (q_not_empty),
        .count     (q_count)
    );

    assign m_tvalid = q_not_empty;
    assign m_tdata  = {7'd0, q_head.halted, q_head.flag_c, q_head.flag_z, q_head.flag_n,
                       q_head.reg_value, q_head.reg_index, q_head.reg_write_en,
                       q_head.next_fetch};

endmodule

`default_nettype wire

>>> rtl/sic_regfile.sv
// 16 x 32 register file: two registered read ports, one write port.
// Valid bits make never-written registers read as zero. Uses sic_pkg.
`default_nettype none

module sic_regfile (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [3:0]      raddr_a,
    input  wire logic [3:0]      raddr_b,
    output logic [31:0]          rdata_a,
    output logic [31:0]          rdata_b,
    input  wire sic_pkg::rf_wr_t wr
);

    logic [31:0] rf_reg [16];
    logic [15:0] vld_reg;
    logic [31:0] rdata_a_reg;
    logic [31:0] rdata_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr.en)
        begin
            vld_reg[wr.idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            rf_reg[wr.idx] <= wr.data;
        end
        rdata_a_reg <= vld_reg[raddr_a] ? rf_reg[raddr_a] : '0;
        rdata_b_reg <= vld_reg[raddr_b] ? rf_reg[raddr_b] : '0;
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

`default_nettype wire

>>> rtl/sic_dmem.sv
// Word data memory with registered read and a zero-fill sweep after reset.
// Uses sic_pkg for its size and request type.
`default_nettype none

module sic_dmem (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sic_pkg::mem_req_t req,
    output logic [31:0]            rdata,
    output logic                   busy
);

    logic [31:0]                  mem_reg [sic_pkg::MEM_WORDS];
    logic [31:0]                  rdata_reg;
    logic                         clr_busy_reg;
    logic [sic_pkg::MEM_AW-1:0]   clr_addr_reg;

    // Sweep every word to zero, one per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + sic_pkg::MEM_AW'(1);
            if (clr_addr_reg == sic_pkg::MEM_AW'(sic_pkg::MEM_WORDS - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem_reg[clr_addr_reg] <= '0;
        end
        else if (req.wr)
        begin
            mem_reg[req.addr] <= req.data;
        end
        rdata_reg <= mem_reg[req.addr];
    end

    assign rdata = rdata_reg;
    assign busy  = clr_busy_reg;

endmodule

`default_nettype wire

>>> rtl/sic_execute.sv
// Decode and execute of one instruction word: ALU, flags, branch target,
// transfer address. Purely combinational; uses sic_pkg.
`default_nettype none

module sic_execute (
    input  wire logic              valid,
    input  wire logic [31:0]       instr,
    input  wire logic [31:0]       op_a,
    input  wire logic [31:0]       op_b,
    input  wire logic [31:0]       pc,
    input  wire sic_pkg::flags_t   flags,
    output sic_pkg::result_t       res,
    output logic                   is_load,
    output sic_pkg::mem_req_t      mem_req,
    output sic_pkg::flags_t        flags_next
);

    sic_pkg::fmt_t fmt;
    logic [3:0]    opcode;
    logic [5:0]    xop;
    logic [31:0]   opnd2;
    logic [31:0]   diff;
    logic [31:0]   addr;
    logic [31:0]   br_off;
    logic [32:0]   adc_sum;
    logic          taken;

    assign fmt     = sic_pkg::fmt_t'(instr[27:26]);
    assign opcode  = instr[24:21];
    assign xop     = instr[25:20];
    assign opnd2   = instr[25] ? {24'd0, instr[7:0]} : op_b;
    assign diff    = op_a - opnd2;
    assign adc_sum = {1'b0, op_a} + {1'b0, opnd2} + {32'd0, flags.c};
    assign addr    = op_a + {20'd0, instr[11:0]};
    assign br_off  = {{6{instr[23]}}, instr[23:0], 2'b00};

    always_comb
    begin
        unique case (instr[31:28])
            sic_pkg::COND_EQ: taken = flags.z;
            sic_pkg::COND_NE: taken = !flags.z;
            sic_pkg::COND_GE: taken = flags.z || !flags.n;
            sic_pkg::COND_LT: taken = !flags.z && flags.n;
            sic_pkg::COND_GT: taken = !flags.z && !flags.n;
            sic_pkg::COND_LE: taken = flags.z || flags.n;
            sic_pkg::COND_AL: taken = 1'b1;
            default:          taken = 1'b0;
        endcase
    end

    always_comb
    begin
        res             = '0;
        res.next_fetch  = pc + 32'd4;
        flags_next      = flags;
        is_load         = 1'b0;
        mem_req.wr      = 1'b0;
        mem_req.addr    = addr[sic_pkg::MEM_AW+1:2];
        mem_req.data    = op_b;

        if (instr == sic_pkg::HALT_WORD)
        begin
            res.halted     = 1'b1;
            res.next_fetch = pc;
        end
        else if (instr != '0)
        begin
            unique case (fmt)
                sic_pkg::FMT_DP:
                begin
                    res.reg_write_en = 1'b1;
                    res.reg_index    = instr[15:12];
                    unique case (opcode)
                        sic_pkg::OP_AND: res.reg_value = op_a & opnd2;
                        sic_pkg::OP_EOR: res.reg_value = op_a ^ opnd2;
                        sic_pkg::OP_SUB: res.reg_value = diff;
                        sic_pkg::OP_ADD: res.reg_value = op_a + opnd2;
                        sic_pkg::OP_ADC:
                        begin
                            res.reg_value = adc_sum[31:0];
                            flags_next.c  = adc_sum[32];
                        end
                        sic_pkg::OP_CMP:
                        begin
                            res.reg_write_en = 1'b0;
                            res.reg_index    = '0;
                            flags_next.n     = diff[31];
                            flags_next.z     = (diff == '0);
                            flags_next.c     = 1'b0;
                        end
                        sic_pkg::OP_ORR: res.reg_value = op_a | opnd2;
                        sic_pkg::OP_MOV: res.reg_value = opnd2;
                        sic_pkg::OP_MVN: res.reg_value = ~opnd2;
                        default:
                        begin
                            res.reg_write_en = 1'b0;
                            res.reg_index    = '0;
                        end
                    endcase
                end
                sic_pkg::FMT_XFER:
                begin
                    if (xop == sic_pkg::XOP_STR)
                    begin
                        mem_req.wr = 1'b1;
                    end
                    else if (xop == sic_pkg::XOP_LDR)
                    begin
                        is_load          = 1'b1;
                        res.reg_write_en = 1'b1;
                        res.reg_index    = instr[15:12];
                    end
                end
                sic_pkg::FMT_BR:
                begin
                    if (taken)
                    begin
                        res.next_fetch = pc + 32'd8 + br_off;
                    end
                end
                sic_pkg::FMT_RSVD:
                begin
                end
            endcase
        end

        // Drop side effects for an empty slot
        if (!valid)
        begin
            mem_req.wr = 1'b0;
            flags_next = flags;
        end

        res.flag_n = flags_next.n;
        res.flag_z = flags_next.z;
        res.flag_c = flags_next.c;
    end

endmodule

`default_nettype wire

>>> rtl/sic_out_fifo.sv
// Small result queue between the execute pipeline and the output port.
// Uses sic_pkg for depth and entry type.
`default_nettype none

module sic_out_fifo (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire sic_pkg::result_t           push_data,
    input  wire logic                       pop,
    output sic_pkg::result_t                head,
    output logic                            not_empty,
    output logic [sic_pkg::OUT_CNT_W-1:0]   count
);

    sic_pkg::result_t                buf_reg [sic_pkg::OUT_DEPTH];
    logic [sic_pkg::OUT_AW-1:0]      wr_ptr_reg;
    logic [sic_pkg::OUT_AW-1:0]      rd_ptr_reg;
    logic [sic_pkg::OUT_CNT_W-1:0]   cnt_reg;
    logic [sic_pkg::OUT_CNT_W-1:0]   cnt_next;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + sic_pkg::OUT_CNT_W'(1);
        end
        else if (!push && pop)
        begin
            cnt_next = cnt_reg - sic_pkg::OUT_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + sic_pkg::OUT_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + sic_pkg::OUT_AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head      = buf_reg[rd_ptr_reg];
    assign not_empty = (cnt_reg != '0);
    assign count     = cnt_reg;

endmodule

`default_nettype wire

>>> rtl/sic_checker.sv
// Port-level checks for the subset instruction core, bound to the top level.
// Depends on sic_pkg for port widths.
`default_nettype none

module sic_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [sic_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    // A taken word has a result waiting once it has passed execute and writeback
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> ##3 m_tvalid)
        else $error("no result three cycles after an accepted word");

    // Without a register write, index and value read as zero
    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[32] |-> (m_tdata[68:33] == '0))
        else $error("register index or value set without a write");

    // Halt never writes a register
    a_halt_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[72] |-> !m_tdata[32])
        else $error("halt result carries a register write");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind arm_subset_instruction_core sic_checker u_sic_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

>>> sim/tb_arm_subset_instruction_core.sv
// Self-checking testbench for arm_subset_instruction_core: instruction words in,
// retired results out. Depends on sic_pkg and the core RTL; a built-in
// instruction-level predictor supplies expected results.
`timescale 1ns / 100ps

module tb_arm_subset_instruction_core;

    import sic_pkg::*;

    localparam int unsigned N_RANDOM = 650;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    arm_subset_instruction_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Architectural state of the predictor
    logic [31:0] arch_reg [16];
    logic [31:0] arch_mem [MEM_WORDS];
    logic [31:0] arch_pc;
    logic        fl_n, fl_z, fl_c;

    logic [31:0] instr_q [$];    // words waiting to be sent
    result_t     retire_q [$];   // results expected from the core, oldest first

    int err_cnt   = 0;
    int n_retired = 0;
    int n_ldr     = 0;
    int n_str     = 0;
    int n_taken   = 0;
    int n_halt    = 0;
    int n_cmp     = 0;

    // ---------------------------------------------------------------
    // Predictor: execute one word against the architectural state
    // ---------------------------------------------------------------
    function automatic result_t exec_instr(input logic [31:0] w);
        result_t     res;
        logic [31:0] a, b, r, addr, nxt;
        logic [32:0] sum;
        logic [3:0]  rn, rd;
        logic        wr, take;
        res  = '0;
        nxt  = arch_pc + 32'd4;
        rn   = w[19:16];
        rd   = w[15:12];
        wr   = 1'b0;
        take = 1'b0;
        r    = '0;
        if (w == HALT_WORD)
        begin
            // Halt: nothing changes, fetch address repeats
            res.halted = 1'b1;
            nxt = arch_pc;
            n_halt++;
        end
        else if (w != 32'd0)
        begin
            case (fmt_t'(w[27:26]))
                FMT_DP:
                begin
                    a  = arch_reg[rn];
                    b  = w[25] ? {24'd0, w[7:0]} : arch_reg[w[3:0]];
                    wr = 1'b1;
                    case (w[24:21])
                        OP_AND: r = a & b;
                        OP_EOR: r = a ^ b;
                        OP_SUB: r = a - b;
                        OP_ADD: r = a + b;
                        OP_ADC:
                        begin
                            sum  = {1'b0, a} + {1'b0, b} + {32'd0, fl_c};
                            r    = sum[31:0];
                            fl_c = sum[32];
                        end
                        OP_CMP:
                        begin
                            r    = a - b;
                            fl_n = r[31];
                            fl_z = (r == 32'd0);
                            fl_c = 1'b0;
                            wr   = 1'b0;
                            n_cmp++;
                        end
                        OP_ORR: r = a | b;
                        OP_MOV: r = b;
                        OP_MVN: r = ~b;
                        default: wr = 1'b0;
                    endcase
                end
                FMT_XFER:
                begin
                    addr = arch_reg[rn] + {20'd0, w[11:0]};
                    if (w[25:20] == XOP_STR)
                    begin
                        arch_mem[addr[MEM_AW+1:2]] = arch_reg[rd];
                        n_str++;
                    end
                    else if (w[25:20] == XOP_LDR)
                    begin
                        r  = arch_mem[addr[MEM_AW+1:2]];
                        wr = 1'b1;
                        n_ldr++;
                    end
                end
                FMT_BR:
                begin
                    case (w[31:28])
                        COND_EQ: take = fl_z;
                        COND_NE: take = !fl_z;
                        COND_GE: take = !fl_n || fl_z;
                        COND_LT: take = !fl_z && fl_n;
                        COND_GT: take = !fl_z && !fl_n;
                        COND_LE: take = fl_n || fl_z;
                        COND_AL: take = 1'b1;
                        default: take = 1'b0;
                    endcase
                    if (take)
                    begin
                        nxt = arch_pc + 32'd8 + {{6{w[23]}}, w[23:0], 2'b00};
                        n_taken++;
                    end
                end
                default: ;
            endcase
            if (wr)
            begin
                arch_reg[rd]     = r;
                res.reg_write_en = 1'b1;
                res.reg_index    = rd;
                res.reg_value    = r;
            end
        end
        arch_pc        = nxt;
        res.next_fetch = nxt;
        res.flag_n     = fl_n;
        res.flag_z     = fl_z;
        res.flag_c     = fl_c;
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Instruction encoders
    // ---------------------------------------------------------------
    function automatic logic [31:0] enc_dp(input logic imm, input logic [3:0] op,
                                           input logic [3:0] rn, input logic [3:0] rd,
                                           input logic [11:0] op2);
        return {COND_AL, FMT_DP, imm, op, 1'b0, rn, rd, op2};
    endfunction

    function automatic logic [31:0] enc_xfer(input logic [5:0] xop, input logic [3:0] rn,
                                             input logic [3:0] rd, input logic [11:0] off);
        return {COND_AL, FMT_XFER, xop, rn, rd, off};
    endfunction

    function automatic logic [31:0] enc_br(input logic [3:0] cond, input logic [23:0] off);
        return {cond, FMT_BR, 2'b10, off};
    endfunction

    // Random word, weighted toward the implemented instructions
    logic [3:0]  last_st_rn  = 4'd0;
    logic [11:0] last_st_off = 12'd0;

    function automatic logic [31:0] rand_instr();
        logic [31:0] w;
        logic [3:0]  op;
        logic [5:0]  xop;
        logic [11:0] off;
        logic [3:0]  rn;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            case ($urandom_range(0, 12))
                0:       op = OP_AND;
                1:       op = OP_EOR;
                2:       op = OP_SUB;
                3:       op = OP_ADD;
                4, 9:    op = OP_ADC;
                5, 10:   op = OP_CMP;
                6:       op = OP_ORR;
                7:       op = OP_MOV;
                8:       op = OP_MVN;
                default: op = 4'($urandom);
            endcase
            w = enc_dp(1'($urandom), op, 4'($urandom), 4'($urandom), 12'($urandom));
            w[31:28] = 4'($urandom);
            w[20]    = 1'($urandom);
        end
        else if (pick < 72)
        begin
            xop = $urandom_range(0, 1) ? XOP_STR : XOP_LDR;
            if ($urandom_range(0, 9) == 0)
                xop = 6'($urandom);
            rn  = 4'($urandom);
            off = ($urandom_range(0, 2) == 0) ? 12'($urandom)
                                              : {6'd0, 4'($urandom), 2'($urandom)};
            // Loads often reuse the last store's address form, to read back data
            if (xop == XOP_LDR && $urandom_range(0, 1) == 1)
            begin
                rn  = last_st_rn;
                off = last_st_off;
            end
            if (xop == XOP_STR)
            begin
                last_st_rn  = rn;
                last_st_off = off;
            end
            w = enc_xfer(xop, rn, 4'($urandom), off);
            w[31:28] = 4'($urandom);
        end
        else if (pick < 90)
        begin
            w = enc_br(4'($urandom), 24'($urandom));
            w[25:24] = 2'($urandom);
        end
        else if (pick < 95)
        begin
            w = $urandom;
            w[27:26] = FMT_RSVD;
        end
        else if (pick < 98)
            w = 32'd0;
        else
            w = HALT_WORD;
        return w;
    endfunction

    // ---------------------------------------------------------------
    // Driver: bursts of words with random gaps
    // ---------------------------------------------------------------
    int gap_cnt   = 0;
    int burst_cnt = 1;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            gap_cnt   = 0;
            burst_cnt = $urandom_range(1, 20);
        end
        else if (!(s_tvalid && !s_tready))
        begin
            // Word taken at this edge: predict its result and drop it
            if (s_tvalid)
            begin
                retire_q.push_back(exec_instr(s_tdata));
                void'(instr_q.pop_front());
            end
            if (gap_cnt != 0)
            begin
                s_tvalid <= 1'b0;
                gap_cnt   = gap_cnt - 1;
            end
            else if (instr_q.size() != 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= instr_q[0];
                burst_cnt = burst_cnt - 1;
                if (burst_cnt <= 0)
                begin
                    burst_cnt = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 90)
                                                            : $urandom_range(1, 24);
                    case ($urandom_range(0, 19))
                        0, 1, 2, 3, 4, 5, 6, 7: gap_cnt = 0;
                        17, 18, 19:             gap_cnt = $urandom_range(5, 16);
                        default:                gap_cnt = $urandom_range(1, 4);
                    endcase
                end
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: receiver stall pattern and result checking
    // ---------------------------------------------------------------
    int          stall_cnt = 0;
    logic [11:0] cyc_cnt   = '0;
    result_t     exp_res;

    task automatic check_field(input string fname, input logic [31:0] e, input logic [31:0] a);
        if (e !== a)
        begin
            $display("%0t: result %0d, %s mismatch: expected %h, actual %h",
                     $time, n_retired, fname, e, a);
            err_cnt++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_cnt = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (retire_q.size() == 0)
                begin
                    $display("%0t: unexpected result word, actual %h", $time, m_tdata);
                    err_cnt++;
                end
                else
                begin
                    exp_res = retire_q.pop_front();
                    check_field("next_fetch",   exp_res.next_fetch,   m_tdata[31:0]);
                    check_field("reg_write_en", 32'(exp_res.reg_write_en),
                                32'(m_tdata[32]));
                    check_field("reg_index",    32'(exp_res.reg_index),
                                32'(m_tdata[36:33]));
                    check_field("reg_value",    exp_res.reg_value,    m_tdata[68:37]);
                    check_field("flag_n",       32'(exp_res.flag_n),  32'(m_tdata[69]));
                    check_field("flag_z",       32'(exp_res.flag_z),  32'(m_tdata[70]));
                    check_field("flag_c",       32'(exp_res.flag_c),  32'(m_tdata[71]));
                    check_field("halted",       32'(exp_res.halted),  32'(m_tdata[72]));
                end
                n_retired++;
            end
            // Always ready for a quarter of the time, random stalls otherwise
            cyc_cnt <= cyc_cnt + 12'd1;
            if (cyc_cnt[11:10] == 2'b00)
                m_tready <= 1'b1;
            else if (stall_cnt != 0)
            begin
                m_tready <= 1'b0;
                stall_cnt = stall_cnt - 1;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 6) == 0)
                    stall_cnt = $urandom_range(1, 12);
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus and end of run
    // ---------------------------------------------------------------
    initial
    begin : main_seq
        int i;
        int drain;
        for (i = 0; i < 16; i++)
            arch_reg[i] = '0;
        for (i = 0; i < MEM_WORDS; i++)
            arch_mem[i] = '0;
        arch_pc = '0;
        fl_n    = 1'b0;
        fl_z    = 1'b0;
        fl_c    = 1'b0;

        // Directed part
        instr_q.push_back(32'd0);                                 // zero word skipped
        instr_q.push_back(HALT_WORD);                             // halt, then halt again
        instr_q.push_back(HALT_WORD);
        instr_q.push_back(enc_dp(1'b1, OP_MOV, 4'd0, 4'd1, 12'h0FF));
        instr_q.push_back(enc_dp(1'b1, OP_MVN, 4'd0, 4'd2, 12'h000));   // all ones
        instr_q.push_back(enc_dp(1'b1, OP_ADC, 4'd2, 4'd3, 12'h001));   // carry out
        instr_q.push_back(enc_dp(1'b1, OP_ADC, 4'd1, 4'd4, 12'h000));   // carry in
        instr_q.push_back(enc_dp(1'b1, OP_CMP, 4'd1, 4'd0, 12'h0FF));   // Z set
        instr_q.push_back(enc_br(COND_EQ, 24'd2));
        instr_q.push_back(enc_br(COND_NE, 24'd5));
        instr_q.push_back(enc_dp(1'b1, OP_CMP, 4'd0, 4'd0, 12'h001));   // N set
        instr_q.push_back(enc_br(COND_LT, 24'hFFFFFC));
        instr_q.push_back(enc_br(COND_GE, 24'd3));
        instr_q.push_back(enc_br(COND_LE, 24'h7FFFFF));
        instr_q.push_back(enc_br(COND_AL, 24'h800000));
        instr_q.push_back(enc_dp(1'b1, OP_SUB, 4'd0, 4'd5, 12'h001));   // wraps below zero
        instr_q.push_back(enc_dp(1'b0, OP_ADD, 4'd2, 4'd6, 12'h002));   // wraps above max
        instr_q.push_back(enc_dp(1'b0, OP_AND, 4'd6, 4'd7, 12'h001));
        instr_q.push_back(enc_dp(1'b0, OP_EOR, 4'd2, 4'd8, 12'h001));
        instr_q.push_back(enc_dp(1'b0, OP_ORR, 4'd1, 4'd9, 12'h004));
        instr_q.push_back(enc_dp(1'b1, OP_MOV, 4'd0, 4'd15, 12'h044));  // r15 is plain
        instr_q.push_back(enc_xfer(XOP_STR, 4'd15, 4'd2, 12'hFFF));     // index wraps
        instr_q.push_back(enc_xfer(XOP_LDR, 4'd0, 4'd10, 12'h040));
        instr_q.push_back(enc_xfer(XOP_LDR, 4'd2, 4'd11, 12'h001));     // address wraps
        instr_q.push_back(enc_dp(1'b0, OP_CMP, 4'd2, 4'd0, 12'h001));
        instr_q.push_back(enc_dp(1'b0, 4'd3, 4'd1, 4'd12, 12'h001));    // unlisted opcode
        instr_q.push_back(enc_xfer(6'd26, 4'd1, 4'd13, 12'h000));       // unlisted transfer
        instr_q.push_back(32'h0C00_1234);                               // reserved format
        instr_q.push_back(enc_br(4'hF, 24'd7));                         // unlisted condition

        for (i = 0; i < N_RANDOM; i++)
            instr_q.push_back(rand_instr());

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Hold until every word is taken, then let the results drain
        while (instr_q.size() != 0 || s_tvalid)
            @(posedge clk);
        for (drain = 0; drain < 4000 && retire_q.size() != 0; drain++)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (retire_q.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, retire_q.size());
            err_cnt++;
        end

        $display("Retired %0d words: %0d loads, %0d stores, %0d compares,",
                 n_retired, n_ldr, n_str, n_cmp);
        $display("  %0d taken branches and %0d halts, under random gaps and stalls",
                 n_taken, n_halt);
        if (err_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("Timeout at %0t", $time);
        $display("TEST FAILED");
        $finish;
    end

endmodule

>>> files.f
rtl/sic_pkg.sv
rtl/sic_regfile.sv
rtl/sic_dmem.sv
rtl/sic_execute.sv
rtl/sic_out_fifo.sv
rtl/arm_subset_instruction_core.sv
rtl/sic_checker.sv
sim/tb_arm_subset_instruction_core.sv
